/* rtl/fcss_pkg.sv */
// shared types and constants for the fasta cpg site scanner
package fcss_pkg;

    localparam int RecW = 16;
    localparam int ValW = 32;
    localparam int ResDepthDefault = 8;

    localparam logic [7:0] ChGt = 8'h3E;  // '>'
    localparam logic [7:0] ChNl = 8'h0A;  // newline
    localparam logic [7:0] ChCu = 8'h43;  // 'C'
    localparam logic [7:0] ChCl = 8'h63;  // 'c'
    localparam logic [7:0] ChGu = 8'h47;  // 'G'
    localparam logic [7:0] ChGl = 8'h67;  // 'g'

    localparam logic [ValW-1:0] Sat32 = '1;
    localparam logic [RecW-1:0] Sat16 = '1;

    typedef enum logic {
        KIND_SITE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [RecW-1:0]  record_number;
        logic [ValW-1:0]  value;
        logic [ValW-1:0]  site_count;
        logic             last;
    } result_t;

    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } push_t;

endpackage

/* rtl/fcss_scan.sv */
// record and cpg tracking state with the results each registered byte causes
module fcss_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_eof,
    output fcss_pkg::result_t res_first,
    output fcss_pkg::result_t res_second,
    output fcss_pkg::push_t   push
);
    import fcss_pkg::*;

    logic            in_header_reg, in_header_next;
    logic            record_open_reg, record_open_next;
    logic            prev_was_c_reg, prev_was_c_next;
    logic [ValW-1:0] position_reg, position_next;
    logic [ValW-1:0] sites_reg, sites_next;
    logic [RecW-1:0] record_reg, record_next;

    logic    is_nl, is_gt, is_c, is_g;
    logic    a_valid, b_valid;
    result_t res_a, res_b;

    assign is_nl = (in_byte == ChNl);
    assign is_gt = (in_byte == ChGt);
    assign is_c  = (in_byte == ChCu) || (in_byte == ChCl);
    assign is_g  = (in_byte == ChGu) || (in_byte == ChGl);

    always_comb begin
        in_header_next   = in_header_reg;
        record_open_next = record_open_reg;
        prev_was_c_next  = prev_was_c_reg;
        position_next    = position_reg;
        sites_next       = sites_reg;
        record_next      = record_reg;
        a_valid          = 1'b0;
        b_valid          = 1'b0;
        res_a            = '0;
        res_b            = '0;
        if (in_valid) begin
            if (in_header_reg) begin
                if (is_nl) begin
                    in_header_next = 1'b0;
                end
            end else if (is_gt) begin
                if (record_open_reg) begin
                    a_valid             = 1'b1;
                    res_a.kind          = KIND_SUMMARY;
                    res_a.record_number = record_reg;
                    res_a.value         = position_reg;
                    res_a.site_count    = sites_reg;
                    if (record_reg != Sat16) begin
                        record_next = record_reg + RecW'(1);
                    end
                end
                record_open_next = 1'b1;
                in_header_next   = 1'b1;
                prev_was_c_next  = 1'b0;
                position_next    = '0;
                sites_next       = '0;
            end else if (record_open_reg && !is_nl) begin
                if (prev_was_c_reg && is_g) begin
                    a_valid             = 1'b1;
                    res_a.kind          = KIND_SITE;
                    res_a.record_number = record_reg;
                    res_a.value         = position_reg - ValW'(1);
                    res_a.site_count    = '0;
                    if (sites_reg != Sat32) begin
                        sites_next = sites_reg + ValW'(1);
                    end
                end
                prev_was_c_next = is_c;
                if (position_reg != Sat32) begin
                    position_next = position_reg + ValW'(1);
                end
            end
            // end of file: summarise the open record, then back to reset state
            if (in_eof) begin
                if (record_open_next) begin
                    b_valid             = 1'b1;
                    res_b.kind          = KIND_SUMMARY;
                    res_b.record_number = record_next;
                    res_b.value         = position_next;
                    res_b.site_count    = sites_next;
                end
                in_header_next   = 1'b0;
                record_open_next = 1'b0;
                prev_was_c_next  = 1'b0;
                position_next    = '0;
                sites_next       = '0;
                record_next      = '0;
            end
        end
        res_a.last = !b_valid;
        res_b.last = 1'b1;
    end

    always_comb begin
        res_first         = a_valid ? res_a : res_b;
        res_second        = res_b;
        push.first_valid  = a_valid || b_valid;
        push.second_valid = a_valid && b_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_header_reg   <= 1'b0;
            record_open_reg <= 1'b0;
            prev_was_c_reg  <= 1'b0;
            position_reg    <= '0;
            sites_reg       <= '0;
            record_reg      <= '0;
        end else begin
            in_header_reg   <= in_header_next;
            record_open_reg <= record_open_next;
            prev_was_c_reg  <= prev_was_c_next;
            position_reg    <= position_next;
            sites_reg       <= sites_next;
            record_reg      <= record_next;
        end
    end

endmodule

/* rtl/fcss_rq.sv */
// result queue taking up to two words a cycle and giving one
module fcss_rq #(
    parameter int Depth = fcss_pkg::ResDepthDefault
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fcss_pkg::push_t             push,
    input  fcss_pkg::result_t           d_first,
    input  fcss_pkg::result_t           d_second,
    input  logic                        pop,
    output fcss_pkg::result_t           head,
    output logic                        head_valid,
    output logic [$clog2(Depth+1)-1:0]  count
);
    import fcss_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    result_t         slots [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push.second_valid) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end else if (push.first_valid) begin
            wr_ptr_next = wr_ptr_inc;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push.first_valid) + CntW'(push.second_valid)
                      - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.first_valid) begin
            slots[wr_ptr_reg] <= d_first;
        end
        if (push.second_valid) begin
            slots[wr_ptr_inc] <= d_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = slots[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

/* rtl/fasta_cpg_site_scanner_core.sv */
// Scans a FASTA byte stream, one byte per word, and reports CpG sites and
// per-record summaries (index, sequence length, CpG count). A byte is taken
// every cycle while the result queue has room for two words from the byte in
// flight and two from the byte being offered; s_tready is low during reset. A
// result word goes through the input register, then the queue write, before
// it shows on m_tvalid. A byte makes at most two result words and the output
// side moves one word a cycle, so sustained input is one byte per cycle when
// output is never stalled and no more than one word per byte is produced on
// average; the queue holds ResDepth words.
module fasta_cpg_site_scanner_core #(
    parameter int ResDepth = fcss_pkg::ResDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] record_number, [47:16] value, [79:48] site_count
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);
    import fcss_pkg::*;

    localparam int CntW = $clog2(ResDepth + 1);
    localparam int SumW = CntW + 2;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_eof_reg;
    result_t         res_first, res_second, head;
    push_t           push;
    logic            head_valid;
    logic [CntW-1:0] count;
    logic [SumW-1:0] need;

    // room for an in-flight byte and the one being offered
    assign need     = SumW'(count) + (in_valid_reg ? SumW'(4) : SumW'(2));
    assign s_tready = aresetn && (need <= SumW'(ResDepth));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eof_reg  <= s_tlast;
        end
    end

    fcss_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .in_eof     (in_eof_reg),
        .res_first  (res_first),
        .res_second (res_second),
        .push       (push)
    );

    fcss_rq #(
        .Depth (ResDepth)
    ) u_rq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .d_first    (res_first),
        .d_second   (res_second),
        .pop        (head_valid && m_tready),
        .head       (head),
        .head_valid (head_valid),
        .count      (count)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = {head.site_count, head.value, head.record_number};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule

/* rtl/fcss_checker.sv */
// port-level checks for the fasta cpg site scanner, bound to the top level
module fcss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import fcss_pkg::*;

    // a held result word does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word shown right after reset");

    // site words carry no count
    a_site_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SITE) |-> m_tdata[79:48] == '0)
        else $error("site word with nonzero site count");

    // a site word can never report the saturated position
    a_site_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SITE) |-> m_tdata[47:16] != Sat32)
        else $error("site word at saturated position");

endmodule

bind fasta_cpg_site_scanner_core fcss_checker u_fcss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/tb_fasta_cpg_site_scanner_core.sv */
// self-checking testbench for the fasta cpg site scanner core
module tb_fasta_cpg_site_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fcss_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_style_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // scanner state as the block should hold it
    logic            hdr_open;
    logic            rec_live;
    logic            prior_c;
    logic [ValW-1:0] seq_len;
    logic [ValW-1:0] cpg_seen;
    logic [RecW-1:0] rec_idx;

    result_t      cpg_reports_due[$];
    result_t      head_word;
    int           mismatch_count = 0;
    int           gap_max = 0;
    int           burst_left = 0;
    int           stall_phase = 0;
    int           hold_len = 0;
    int           guard = 0;
    logic         hold_active = 1'b0;
    ready_style_t ready_style = READY_ALWAYS;
    event         hold_go;

    fasta_cpg_site_scanner_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic clear_scan_state();
        hdr_open = 1'b0;
        rec_live = 1'b0;
        prior_c  = 1'b0;
        seq_len  = '0;
        cpg_seen = '0;
        rec_idx  = '0;
    endtask

    function automatic result_t make_word(input kind_t k, input logic [ValW-1:0] v,
                                          input logic [ValW-1:0] c);
        result_t w;
        w.kind          = k;
        w.record_number = rec_idx;
        w.value         = v;
        w.site_count    = c;
        w.last          = 1'b0;
        return w;
    endfunction

    // advance the scanner by one byte and queue the words it must produce
    task automatic scan_fasta_byte(input logic [7:0] b, input logic eof);
        result_t due[2];
        int n;
        n = 0;
        if (hdr_open) begin
            if (b == ChNl)
                hdr_open = 1'b0;
        end else if (b == ChGt) begin
            if (rec_live) begin
                due[n] = make_word(KIND_SUMMARY, seq_len, cpg_seen);
                n++;
                if (rec_idx != Sat16)
                    rec_idx++;
            end
            rec_live = 1'b1;
            hdr_open = 1'b1;
            prior_c  = 1'b0;
            seq_len  = '0;
            cpg_seen = '0;
        end else if (rec_live && b != ChNl) begin
            if (prior_c && (b == ChGu || b == ChGl)) begin
                // with the position saturated this still reports one below it
                due[n] = make_word(KIND_SITE, seq_len - 1, '0);
                n++;
                if (cpg_seen != Sat32)
                    cpg_seen++;
            end
            prior_c = (b == ChCu || b == ChCl);
            if (seq_len != Sat32)
                seq_len++;
        end
        if (eof) begin
            if (rec_live) begin
                due[n] = make_word(KIND_SUMMARY, seq_len, cpg_seen);
                n++;
            end
            clear_scan_state();
        end
        if (n > 0)
            due[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            cpg_reports_due.insert(cpg_reports_due.size(), due[i]);
    endtask

    task automatic send_word(input logic [7:0] b, input logic eof);
        if (gap_max > 0 && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        scan_fasta_byte(b, eof);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (cpg_reports_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] next_seq_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return ($urandom_range(0, 1) != 0) ? ChCu : ChCl;
        else if (r < 55)
            return ($urandom_range(0, 1) != 0) ? ChGu : ChGl;
        else if (r < 70)
            return ($urandom_range(0, 1) != 0) ? "A" : "a";
        else if (r < 80)
            return ($urandom_range(0, 1) != 0) ? "T" : "t";
        else if (r < 85)
            return "N";
        else if (r < 88)
            return 8'h0D;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver ready: a pattern of its own, overridden by a long hold-off
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (!aresetn || hold_active) begin
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                READY_PATTERN: m_tready <= (stall_phase % 5) < 3;
                default:       m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial forever begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (hold_len) @(posedge aclk);
        hold_active <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cpg_reports_due.size() == 0) begin
                report_mismatch("word with nothing due", m_tdata[47:16], 0);
            end else begin
                head_word = cpg_reports_due.pop_front();
                if (m_tuser !== head_word.kind)
                    report_mismatch("kind", m_tuser, head_word.kind);
                if (m_tdata[15:0] !== head_word.record_number)
                    report_mismatch("record_number", m_tdata[15:0], head_word.record_number);
                if (m_tdata[47:16] !== head_word.value)
                    report_mismatch("value", m_tdata[47:16], head_word.value);
                if (m_tdata[79:48] !== head_word.site_count)
                    report_mismatch("site_count", m_tdata[79:48], head_word.site_count);
                if (m_tlast !== head_word.last)
                    report_mismatch("last", m_tlast, head_word.last);
            end
        end
    end

    task automatic test_directed();
        gap_max = 3;
        ready_style = READY_PATTERN;
        send_word(8'h00, 1'b1);                       // end of file with nothing open
        send_word(8'hFF, 1'b0);                       // ignored before the first record
        send_word(ChGt, 1'b0);
        send_word(ChGt, 1'b0);                        // '>' taken as name text
        send_word("n", 1'b0);
        send_word(ChNl, 1'b0);
        send_word(ChCu, 1'b0);
        send_word(ChNl, 1'b0);                        // site across a line break
        send_word(ChGl, 1'b0);
        send_word(8'h0D, 1'b0);                       // carriage return counts
        send_word(ChCl, 1'b0);
        send_word(ChGu, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(ChCu, 1'b0);
        send_word(8'h00, 1'b0);                       // breaks the c-g pair
        send_word(ChGt, 1'b0);
        send_word(ChNl, 1'b0);
        send_word(ChCl, 1'b0);
        send_word(ChGl, 1'b1);                        // site then summary on one byte
        send_word(ChGt, 1'b0);
        send_word(ChNl, 1'b0);
        send_word("A", 1'b0);
        send_word(ChGt, 1'b1);                        // two summaries, empty record last
        send_word(ChGt, 1'b0);
        send_word("a", 1'b0);
        send_word("b", 1'b1);                         // header never ended
        drain_results();
    endtask

    task automatic test_output_hold();
        gap_max = 0;
        ready_style = READY_ALWAYS;
        hold_len = 300;
        -> hold_go;
        send_word(ChGt, 1'b0);
        send_word(ChNl, 1'b0);
        for (int i = 0; i < 100; i++)
            send_word((i % 2 == 0) ? ChCu : ChGu, 1'b0);
        send_word("T", 1'b1);
        drain_results();
    endtask

    task automatic test_random_files(input int target);
        logic [7:0] fbytes[$];
        int sent;
        int nrec;
        int line_len;
        int col;
        sent = 0;
        while (sent < target) begin
            fbytes.delete();
            ready_style = ready_style_t'($urandom_range(0, 3));
            gap_max = $urandom_range(0, 6);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6))
                    fbytes.insert(fbytes.size(), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0) begin
                // pure noise file
                repeat ($urandom_range(5, 40))
                    fbytes.insert(fbytes.size(), 8'($urandom_range(0, 255)));
            end else begin
                nrec = $urandom_range(1, 4);
                repeat (nrec) begin
                    fbytes.insert(fbytes.size(), ChGt);
                    repeat ($urandom_range(0, 8))
                        fbytes.insert(fbytes.size(), ($urandom_range(0, 9) == 0) ? ChGt
                                      : 8'($urandom_range(8'h20, 8'h7E)));
                    if ($urandom_range(0, 9) != 0)
                        fbytes.insert(fbytes.size(), ChNl);
                    line_len = $urandom_range(1, 12);
                    col = 0;
                    repeat ($urandom_range(0, 60)) begin
                        fbytes.insert(fbytes.size(), next_seq_byte());
                        col++;
                        if (col == line_len) begin
                            fbytes.insert(fbytes.size(), ChNl);
                            col = 0;
                        end
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    fbytes.insert(fbytes.size(), ChGt);
            end
            for (int i = 0; i < fbytes.size(); i++)
                send_word(fbytes[i], i == fbytes.size() - 1);
            sent += fbytes.size();
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
    endtask

    // many short records in one file
    task automatic test_many_records();
        gap_max = 0;
        ready_style = READY_ALWAYS;
        for (int i = 0; i < 50; i++) begin
            send_word(ChGt, 1'b0);
            send_word(ChNl, 1'b0);
        end
        send_word(ChCu, 1'b0);
        send_word(ChGu, 1'b1);
    endtask

    initial begin
        clear_scan_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_hold();
        test_random_files(1000);
        drain_results();
        test_many_records();
        s_tvalid <= 1'b0;
        while (cpg_reports_due.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        if (cpg_reports_due.size() != 0)
            report_mismatch("words never delivered", cpg_reports_due.size(), 0);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/fcss_pkg.sv
rtl/fcss_scan.sv
rtl/fcss_rq.sv
rtl/fasta_cpg_site_scanner_core.sv
rtl/fcss_checker.sv
tb/tb_fasta_cpg_site_scanner_core.sv
